@@ sv/sdf_pkg.sv @@
// Shared types and constants of the set-data message framer.
`timescale 1ns / 1ps
package sdf_pkg;

    localparam logic [7:0] SX_START = 8'hF0;
    localparam logic [7:0] SX_MFR   = 8'h41;
    localparam logic [7:0] SX_END   = 8'hF7;

    localparam logic [6:0] DEVICE_ID_RST  = 7'h10;
    localparam logic [6:0] MODEL_ID_RST   = 7'h16;
    localparam logic [6:0] COMMAND_ID_RST = 7'h12;

    localparam int BASE_W = 23;
    localparam int OFFS_W = 16;
    localparam int ADDR_W = 21;
    localparam int S_TDATA_W = 48;
    localparam int PADDR_W = 4;

    // Register indexes, at byte address 4*index.
    localparam logic [1:0] REG_DEVICE_ID  = 2'd0;
    localparam logic [1:0] REG_MODEL_ID   = 2'd1;
    localparam logic [1:0] REG_COMMAND_ID = 2'd2;

    typedef struct packed {
        logic [6:0] device_id;
        logic [6:0] model_id;
        logic [6:0] command_id;
    } t_ids;

    // One accepted payload beat with its address already in 7-bit byte form.
    typedef struct packed {
        logic [6:0] addr_hi;
        logic [6:0] addr_mid;
        logic [6:0] addr_lo;
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_item;

endpackage

@@ sv/sdf_addr.sv @@
// Address unpack, offset add and repack into three 7-bit bytes.
`timescale 1ns / 1ps
module sdf_addr (
    input  logic [sdf_pkg::BASE_W-1:0] i_base_address,
    input  logic [sdf_pkg::OFFS_W-1:0] i_offset,
    output logic [6:0]                 o_addr_hi,
    output logic [6:0]                 o_addr_mid,
    output logic [6:0]                 o_addr_lo
);
    import sdf_pkg::*;

    logic [ADDR_W-1:0] lin_base;
    logic [ADDR_W-1:0] lin_sum;

    // Drop bits 7 and 15 of the packed base.
    assign lin_base = {i_base_address[22:16], i_base_address[14:8], i_base_address[6:0]};
    assign lin_sum  = ADDR_W'(lin_base + ADDR_W'(i_offset));

    assign o_addr_hi  = lin_sum[20:14];
    assign o_addr_mid = lin_sum[13:7];
    assign o_addr_lo  = lin_sum[6:0];

endmodule

@@ sv/sdf_regs.sv @@
// APB register bank for the identifier bytes.
`timescale 1ns / 1ps
module sdf_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sdf_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output sdf_pkg::t_ids                o_ids
);
    import sdf_pkg::*;

    t_ids       r_ids;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_ids   = r_ids;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ids.device_id  <= DEVICE_ID_RST;
            r_ids.model_id   <= MODEL_ID_RST;
            r_ids.command_id <= COMMAND_ID_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DEVICE_ID:  r_ids.device_id  <= pwdata[6:0];
                REG_MODEL_ID:   r_ids.model_id   <= pwdata[6:0];
                REG_COMMAND_ID: r_ids.command_id <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEVICE_ID:  prdata = {25'd0, r_ids.device_id};
            REG_MODEL_ID:   prdata = {25'd0, r_ids.model_id};
            REG_COMMAND_ID: prdata = {25'd0, r_ids.command_id};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

@@ sv/sdf_emit.sv @@
// Byte sequencer: header, address, payload, checksum and end byte into the output register.
`timescale 1ns / 1ps
module sdf_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sdf_pkg::t_ids  i_ids,
    input  sdf_pkg::t_item i_item,
    input  logic           i_item_valid,
    output logic           o_item_take,
    output logic           o_tvalid,
    output logic [7:0]     o_tdata,
    output logic           o_tlast,
    input  logic           i_tready
);
    import sdf_pkg::*;

    typedef enum logic [3:0] {
        ST_START, ST_MFR, ST_DEV, ST_MODEL, ST_CMD,
        ST_ADDR_HI, ST_ADDR_MID, ST_ADDR_LO, ST_DATA, ST_CHK, ST_END
    } t_step;

    t_step      r_step;
    t_step      cur_step;
    t_step      next_step;
    logic       r_in_msg;
    logic [6:0] r_sum;
    logic       out_free;
    logic       drop;
    logic       emit;
    logic       final_step;
    logic [7:0] cur_byte;
    logic [6:0] sum_base;
    logic [6:0] sum_data;

    assign out_free = !o_tvalid || i_tready;
    // A beat outside a message that does not open one is discarded.
    assign drop     = !i_item.first && !r_in_msg;
    assign emit     = i_item_valid && !drop && out_free;
    assign cur_step = (r_step == ST_START && !i_item.first) ? ST_DATA : r_step;
    assign final_step = (cur_step == ST_DATA && !i_item.last) || (cur_step == ST_END);
    assign o_item_take = i_item_valid && (drop || (out_free && final_step));

    assign sum_base = i_item.first
                    ? 7'(i_item.addr_hi + i_item.addr_mid + i_item.addr_lo) : r_sum;
    assign sum_data = 7'(sum_base + i_item.data[6:0]);

    always_comb begin
        case (cur_step)
            ST_START:    begin cur_byte = SX_START;                   next_step = ST_MFR;      end
            ST_MFR:      begin cur_byte = SX_MFR;                     next_step = ST_DEV;      end
            ST_DEV:      begin cur_byte = {1'b0, i_ids.device_id};    next_step = ST_MODEL;    end
            ST_MODEL:    begin cur_byte = {1'b0, i_ids.model_id};     next_step = ST_CMD;      end
            ST_CMD:      begin cur_byte = {1'b0, i_ids.command_id};   next_step = ST_ADDR_HI;  end
            ST_ADDR_HI:  begin cur_byte = {1'b0, i_item.addr_hi};     next_step = ST_ADDR_MID; end
            ST_ADDR_MID: begin cur_byte = {1'b0, i_item.addr_mid};    next_step = ST_ADDR_LO;  end
            ST_ADDR_LO:  begin cur_byte = {1'b0, i_item.addr_lo};     next_step = ST_DATA;     end
            ST_DATA:     begin cur_byte = i_item.data;                next_step = ST_CHK;      end
            ST_CHK:      begin cur_byte = {1'b0, 7'(7'd0 - r_sum)};   next_step = ST_END;      end
            ST_END:      begin cur_byte = SX_END;                     next_step = ST_START;    end
            default:     begin cur_byte = SX_END;                     next_step = ST_START;    end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= ST_START;
            r_in_msg <= 1'b0;
            r_sum    <= 7'd0;
            o_tvalid <= 1'b0;
        end else begin
            if (out_free) begin
                o_tvalid <= emit;
            end
            if (emit) begin
                o_tdata <= cur_byte;
                o_tlast <= (cur_step == ST_END);
                r_step  <= o_item_take ? ST_START : next_step;
                if (cur_step == ST_DATA) begin
                    r_sum <= sum_data;
                    if (i_item.first) begin
                        r_in_msg <= 1'b1;
                    end
                end
                if (cur_step == ST_END) begin
                    r_in_msg <= 1'b0;
                    r_sum    <= 7'd0;
                end
            end
        end
    end

    a_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && o_tlast |-> o_tdata == SX_END)
        else $error("end flag on a byte other than the end byte");

    a_take_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_take |=> r_step == ST_START)
        else $error("sequencer not rewound after beat was taken");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && cur_step == ST_END |=> !r_in_msg && r_sum == 7'd0)
        else $error("message still open after end byte");

    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid && drop |-> !emit && o_item_take)
        else $error("dropped beat produced output or was not discarded");

endmodule

@@ sv/sysex_set_data_framer_top.sv @@
// Top level of the set-data message framer.
`timescale 1ns / 1ps
// Frames payload beats into 7-bit-address set-data system exclusive messages.
// A beat with the first flag (s_axis_tuser) produces eight header and
// address bytes ahead of its payload byte: F0, 41, device, model and
// command bytes, and the base address plus offset as three 7-bit bytes.
// Each middle payload beat produces only its payload byte. A beat with
// tlast adds the checksum and F7 (output tlast high on F7). A single byte
// sequencer drives the output register. A beat outside a message without
// the first flag is discarded without output. The input register takes
// the next beat in the cycle the current one finishes, so payload streams
// at one byte per clock while the output is ready.
module sysex_set_data_framer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // s_axis_tdata: base_address[22:0], offset[38:23], data_byte[46:39], zero pad
    input  logic [sdf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tuser,   // first_byte
    input  logic                           s_axis_tlast,   // last_byte
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // m_axis_tdata: out_byte[7:0]
    output logic [7:0]                     m_axis_tdata,
    output logic                           m_axis_tlast,   // end_of_message
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sdf_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import sdf_pkg::*;

    t_ids       ids;
    t_item      r_item;
    t_item      n_item;
    logic [6:0] addr_hi;
    logic [6:0] addr_mid;
    logic [6:0] addr_lo;
    logic       r_item_valid;
    logic       item_take;
    logic       s_fire;

    sdf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ids   (ids)
    );

    sdf_addr u_addr (
        .i_base_address (s_axis_tdata[22:0]),
        .i_offset       (s_axis_tdata[38:23]),
        .o_addr_hi      (addr_hi),
        .o_addr_mid     (addr_mid),
        .o_addr_lo      (addr_lo)
    );

    assign n_item = {addr_hi, addr_mid, addr_lo, s_axis_tdata[46:39], s_axis_tuser,
                     s_axis_tlast};

    assign s_axis_tready = !r_item_valid || item_take;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_item_valid <= 1'b1;
            end else if (item_take) begin
                r_item_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_item <= n_item;
        end
    end

    sdf_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ids        (ids),
        .i_item       (r_item),
        .i_item_valid (r_item_valid),
        .o_item_take  (item_take),
        .o_tvalid     (m_axis_tvalid),
        .o_tdata      (m_axis_tdata),
        .o_tlast      (m_axis_tlast),
        .i_tready     (m_axis_tready)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the set-data message framer.
`timescale 1ns / 1ps
module testbench;
    import sdf_pkg::*;

    // Watchdog limit, sized for the slowest run with output stalls and input gaps.
    localparam int LIMIT = 300000;
    localparam int DRAIN = 24;
    localparam int N_DIR = 17;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [OFFS_W-1:0] offs;
        logic [7:0]        data;
        logic              first_b;
        logic              last_b;
        logic              chk_known;
        logic [7:0]        chk;
    } t_row;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       eom;
    } t_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 s_axis_tlast = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Predictor state
    t_ids       ids = '{DEVICE_ID_RST, MODEL_ID_RST, COMMAND_ID_RST};
    logic [6:0] sum7 = '0;
    bit         msg_open = 1'b0;
    t_out       expected_bytes[$];

    bit          stall_on = 1'b1;
    int unsigned errors = 0;
    int unsigned n_beats = 0;
    int unsigned n_msgs = 0;
    int unsigned n_out = 0;
    int unsigned cycles = 0;
    t_out        want;

    // base, offs, data, first, last, checksum typed?, checksum
    t_row dir_tab [N_DIR] = '{
        '{23'h000000, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00},
        '{23'h7F7F7F, 16'h0000, 8'hFF, 1'b1, 1'b1, 1'b1, 8'h04},
        '{23'h7F7F7F, 16'h0001, 8'h80, 1'b1, 1'b1, 1'b1, 8'h00},
        '{23'h008080, 16'h0000, 8'h01, 1'b1, 1'b1, 1'b1, 8'h7F},
        '{23'h000000, 16'hFFFF, 8'h7F, 1'b1, 1'b1, 1'b1, 8'h00},
        '{23'h000000, 16'h0000, 8'h5A, 1'b0, 1'b0, 1'b0, 8'h00},
        '{23'h000000, 16'h0000, 8'hA5, 1'b0, 1'b1, 1'b0, 8'h00},
        '{23'h123456, 16'h0100, 8'h11, 1'b1, 1'b0, 1'b0, 8'h00},
        '{23'h7FFFFF, 16'hFFFF, 8'h22, 1'b0, 1'b0, 1'b0, 8'h00},
        '{23'h000000, 16'h0000, 8'hFE, 1'b0, 1'b1, 1'b0, 8'h00},
        '{23'h7FFFFF, 16'h8000, 8'h33, 1'b1, 1'b0, 1'b0, 8'h00},
        '{23'h000000, 16'h0000, 8'h44, 1'b0, 1'b0, 1'b0, 8'h00},
        '{23'h010203, 16'h0005, 8'h55, 1'b1, 1'b0, 1'b0, 8'h00},
        '{23'h000000, 16'h0000, 8'h80, 1'b0, 1'b0, 1'b0, 8'h00},
        '{23'h000000, 16'h0000, 8'h7F, 1'b0, 1'b1, 1'b0, 8'h00},
        '{23'h2A2A2A, 16'h1234, 8'hC3, 1'b1, 1'b0, 1'b0, 8'h00},
        '{23'h000000, 16'h0000, 8'h3C, 1'b0, 1'b1, 1'b0, 8'h00}
    };

    sysex_set_data_framer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic void push_out(input logic [7:0] b, input logic e);
        expected_bytes.push_back('{b, e});
    endfunction

    // Work out the framed bytes one payload beat causes.
    task automatic predict_frame(input logic [BASE_W-1:0] base, input logic [OFFS_W-1:0] offs,
                                 input logic [7:0] data, input logic first_b,
                                 input logic last_b, output bit counted);
        logic [ADDR_W-1:0] lin;
        counted = first_b || msg_open;
        if (!counted) return;
        if (first_b) begin
            // drop bits 7 and 15 of the packed base
            lin = {base[22:16], base[14:8], base[6:0]} + ADDR_W'(offs);
            push_out(SX_START, 1'b0);
            push_out(SX_MFR, 1'b0);
            push_out({1'b0, ids.device_id}, 1'b0);
            push_out({1'b0, ids.model_id}, 1'b0);
            push_out({1'b0, ids.command_id}, 1'b0);
            push_out({1'b0, lin[20:14]}, 1'b0);
            push_out({1'b0, lin[13:7]}, 1'b0);
            push_out({1'b0, lin[6:0]}, 1'b0);
            sum7 = lin[20:14] + lin[13:7] + lin[6:0];
            msg_open = 1'b1;
        end
        push_out(data, 1'b0);
        sum7 = sum7 + data[6:0];
        if (last_b) begin
            push_out({1'b0, 7'(7'd0 - sum7)}, 1'b0);
            push_out(SX_END, 1'b1);
            sum7 = '0;
            msg_open = 1'b0;
            n_msgs++;
        end
    endtask

    task automatic send_beat(input logic [BASE_W-1:0] base, input logic [OFFS_W-1:0] offs,
                             input logic [7:0] data, input logic first_b, input logic last_b,
                             input bit gaps, output bit counted);
        s_axis_tdata  <= {1'b0, data, offs, base};
        s_axis_tuser  <= first_b;
        s_axis_tlast  <= last_b;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        n_beats++;
        predict_frame(base, offs, data, first_b, last_b, counted);
        if (gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Hold the input until every expected byte is out and the block is idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DEVICE_ID:  ids.device_id  = val[6:0];
            REG_MODEL_ID:   ids.model_id   = val[6:0];
            REG_COMMAND_ID: ids.command_id = val[6:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic read_reg(input logic [1:0] idx, input logic [6:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {25'd0, val}) begin
            $error("prdata reg %0d: expected %h, actual %h", idx, {25'd0, val}, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_ids(input logic [31:0] dev, input logic [31:0] mdl,
                           input logic [31:0] cmd);
        write_reg(REG_DEVICE_ID, dev);
        write_reg(REG_MODEL_ID, mdl);
        write_reg(REG_COMMAND_ID, cmd);
        read_reg(REG_DEVICE_ID, ids.device_id);
        read_reg(REG_MODEL_ID, ids.model_id);
        read_reg(REG_COMMAND_ID, ids.command_id);
    endtask

    // Mostly well-formed messages, some abandoned ones and stray bytes.
    task automatic run_random(input int unsigned n_items, input bit gaps);
        int unsigned got;
        int unsigned len;
        int unsigned kind;
        bit          counted;
        got = 0;
        while (got < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                send_beat(BASE_W'($urandom()), OFFS_W'($urandom()), 8'($urandom()), 1'b0,
                          1'($urandom_range(0, 1)), gaps, counted);
                got += counted;
            end else begin
                len = (kind == 1) ? $urandom_range(1, 20) : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    send_beat(BASE_W'($urandom()),
                              ($urandom_range(0, 3) == 0) ? OFFS_W'($urandom())
                                                          : OFFS_W'($urandom_range(0, 300)),
                              8'($urandom()), i == 0, (kind != 2) && (i == len - 1),
                              gaps, counted);
                    got += counted;
                end
            end
        end
    endtask

    // Output side: random stall bursts while enabled.
    initial begin
        forever begin
            repeat ($urandom_range(1, 40)) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
            if (stall_on) begin
                repeat ($urandom_range(1, 10)) begin
                    m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_out++;
            if (expected_bytes.size() == 0) begin
                $error("out_byte: expected none, actual %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata !== want.out_byte) begin
                    $error("out_byte: expected %h, actual %h", want.out_byte, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.eom) begin
                    $error("end_of_message: expected %b, actual %b", want.eom, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        bit counted;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        read_reg(REG_DEVICE_ID, DEVICE_ID_RST);
        read_reg(REG_MODEL_ID, MODEL_ID_RST);
        read_reg(REG_COMMAND_ID, COMMAND_ID_RST);

        for (int r = 0; r < N_DIR; r++) begin
            send_beat(dir_tab[r].base, dir_tab[r].offs, dir_tab[r].data, dir_tab[r].first_b,
                      dir_tab[r].last_b, 1'b1, counted);
            if (dir_tab[r].chk_known)
                expected_bytes[expected_bytes.size() - 2].out_byte = dir_tab[r].chk;
        end
        settle();

        set_ids(32'd0, 32'd0, 32'd0);
        run_random(75, 1'b1);
        settle();

        // upper bits of pwdata must be dropped
        set_ids(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(75, 1'b1);
        settle();

        set_ids($urandom(), $urandom(), $urandom());
        stall_on = 1'b0;
        run_random(70, 1'b0);
        settle();

        $display("Covered %0d input beats, %0d closed messages, %0d output bytes checked,",
                 n_beats, n_msgs, n_out);
        $display("under reset, all-zero, all-ones and random identifier settings.");
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
